// ===== design/rast_pkg.sv =====
// ----------------------------------------------------------------------------
// rast_pkg
// Shared types and sizes for the range add / range sum block.
// ----------------------------------------------------------------------------
package rast_pkg;

  localparam int unsigned NUM_ELEM = 256;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned LEN_W    = 9;
  localparam int unsigned POS_W    = 10;
  localparam int unsigned CMD_W    = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_SUM   = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_SET,
    ST_QRY_SET,
    ST_WALK_RD,
    ST_WALK_WR,
    ST_MUL,
    ST_FIN,
    ST_OUT
  } state_e;

endpackage

// ===== design/range_add_range_sum_tree_core.sv =====
// ----------------------------------------------------------------------------
// range_add_range_sum_tree_core
// Range add and range sum over up to 256 wrapping 32-bit elements.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one command per
//   transaction: clear, range add or range sum over [left, right], with the
//   range clipped to the active length. Only a range sum returns a
//   transaction on the output channel (out_valid_o / out_stall_i).
//   The configuration channel writes the active length (0 reads as 1,
//   above 256 saturates); a write also clears all elements.
// Internals:
//   Two Fenwick trees (B1, B2) share one 256 x 64 RAM; each entry is read
//   (WALK_RD) and, for an add, written back (WALK_WR) on the single RAM port.
//   Clears drop a bank of per-entry valid bits, so they walk no RAM entry.
// Command flow:
//   clear, empty add and ignored commands leave the block idle. Range add:
//   walks of up to 9 entries from left+1 and 8 from right+2. Range sum:
//   prefix walks of up to 8 entries each, each with a multiply and finish
//   step, then the result registers. The input stalls and takes no new
//   command until the block is back in idle.
// Reset clears the valid bits, the length (256) and the output valid.
// A stalled result holds in the output register; the block still takes the
// next command and only waits if a new sum is ready before the old one left.
module range_add_range_sum_tree_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [rast_pkg::LEN_W-1:0] cfg_active_length_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [rast_pkg::CMD_W-1:0] cmd_i,
  input  logic [rast_pkg::IDX_W-1:0] left_index_i,
  input  logic [rast_pkg::IDX_W-1:0] right_index_i,
  input  logic signed [rast_pkg::VAL_W-1:0] add_value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [rast_pkg::VAL_W-1:0] range_sum_o
);

  localparam int unsigned VW = rast_pkg::VAL_W;
  localparam int unsigned IW = rast_pkg::IDX_W;
  localparam int unsigned LW = rast_pkg::LEN_W;
  localparam int unsigned PW = rast_pkg::POS_W;
  localparam int unsigned NE = rast_pkg::NUM_ELEM;

  rast_pkg::state_e state_q, state_d;

  logic [LW-1:0]    len_q;
  logic [NE-1:0]    vld_q;
  logic             vld_rd_q;
  logic [1:0]       cmd_q;
  logic [IW-1:0]    left_q, rclip_q;
  logic [VW-1:0]    val_q;
  logic             pass_q, pass_d;
  logic [PW-1:0]    pos_q, pos_d;
  logic [LW-1:0]    k_q, k_d;
  logic [VW-1:0]    d1_q, d1_d, d2_q, d2_d;
  logic [VW-1:0]    acc1_q, acc1_d, acc2_q, acc2_d;
  logic [VW-1:0]    prod_q, prod_d;
  logic [VW-1:0]    tot_q, tot_d;
  logic             out_valid_q;
  logic [VW-1:0]    out_data_q;

  logic             in_acc, cfg_acc, clr;
  logic             load_out;
  logic [VW-1:0]    load_val;
  logic [IW-1:0]    last, rclip;
  logic             empty;
  logic [PW-1:0]    lowbit, pos_up, pos_dn;
  logic [IW-1:0]    ram_addr;
  logic             ram_we;
  logic [2*VW-1:0]  ram_wdata, ram_rdata;
  logic [VW-1:0]    old1, old2;
  logic [LW-1:0]    mul_k;
  logic [VW+LW-1:0] mul_full;
  logic [VW+LW-1:0] kmul_full;
  logic [VW-1:0]    pref;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;
  assign in_stall_o  = (state_q != rast_pkg::ST_IDLE);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign clr         = cfg_acc | (in_acc & (cmd_i == rast_pkg::CMD_CLEAR));

  // Clip the range end to the last active element.
  assign last  = IW'(len_q - LW'(1));
  assign rclip = (right_index_i > last) ? last : right_index_i;
  assign empty = left_index_i > rclip;

  assign lowbit = pos_q & (~pos_q + PW'(1));
  assign pos_up = pos_q + lowbit;
  assign pos_dn = pos_q - lowbit;
  assign ram_addr = IW'(pos_q - PW'(1));

  assign old1 = vld_rd_q ? ram_rdata[2*VW-1:VW] : '0;
  assign old2 = vld_rd_q ? ram_rdata[VW-1:0]    : '0;
  assign ram_wdata = {old1 + d1_q, old2 + d2_q};
  assign ram_we = (state_q == rast_pkg::ST_WALK_WR) && (cmd_q == rast_pkg::CMD_ADD);

  assign mul_k    = pass_q ? (LW'(rclip_q) + LW'(1)) : LW'(left_q);
  assign mul_full = val_q * mul_k;
  assign kmul_full = acc1_q * k_q;
  assign pref     = prod_q - acc2_q;

  rast_ram #(
    .WIDTH (2*VW),
    .DEPTH (NE)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d  = state_q;
    pass_d   = pass_q;
    pos_d    = pos_q;
    k_d      = k_q;
    d1_d     = d1_q;
    d2_d     = d2_q;
    acc1_d   = acc1_q;
    acc2_d   = acc2_q;
    prod_d   = prod_q;
    tot_d    = tot_q;
    load_out = 1'b0;
    load_val = tot_q;
    unique case (state_q)
      rast_pkg::ST_IDLE: begin
        pass_d = 1'b0;
        if (in_acc) begin
          case (cmd_i)
            rast_pkg::CMD_ADD: begin
              if (!empty) state_d = rast_pkg::ST_ADD_SET;
            end
            rast_pkg::CMD_SUM: begin
              tot_d = '0;
              state_d = empty ? rast_pkg::ST_OUT : rast_pkg::ST_QRY_SET;
            end
            default: state_d = rast_pkg::ST_IDLE;
          endcase
        end
      end
      rast_pkg::ST_ADD_SET: begin
        // Start point at left+1, stop point at clipped right+2.
        pos_d = pass_q ? (PW'(rclip_q) + PW'(2)) : (PW'(left_q) + PW'(1));
        d1_d  = pass_q ? (VW'(0) - val_q) : val_q;
        d2_d  = pass_q ? (VW'(0) - mul_full[VW-1:0]) : mul_full[VW-1:0];
        if (pass_q && (PW'(rclip_q) + PW'(2)) > PW'(NE)) begin
          state_d = rast_pkg::ST_IDLE;
        end else begin
          state_d = rast_pkg::ST_WALK_RD;
        end
      end
      rast_pkg::ST_QRY_SET: begin
        k_d    = pass_q ? LW'(left_q) : (LW'(rclip_q) + LW'(1));
        pos_d  = PW'(k_d);
        acc1_d = '0;
        acc2_d = '0;
        state_d = (k_d == '0) ? rast_pkg::ST_MUL : rast_pkg::ST_WALK_RD;
      end
      rast_pkg::ST_WALK_RD: begin
        state_d = rast_pkg::ST_WALK_WR;
      end
      rast_pkg::ST_WALK_WR: begin
        if (cmd_q == rast_pkg::CMD_ADD) begin
          pos_d = pos_up;
          if (pos_up > PW'(NE)) begin
            pass_d  = 1'b1;
            state_d = pass_q ? rast_pkg::ST_IDLE : rast_pkg::ST_ADD_SET;
          end else begin
            state_d = rast_pkg::ST_WALK_RD;
          end
        end else begin
          acc1_d = acc1_q + old1;
          acc2_d = acc2_q + old2;
          pos_d  = pos_dn;
          state_d = (pos_dn == '0) ? rast_pkg::ST_MUL : rast_pkg::ST_WALK_RD;
        end
      end
      rast_pkg::ST_MUL: begin
        prod_d  = kmul_full[VW-1:0];
        state_d = rast_pkg::ST_FIN;
      end
      rast_pkg::ST_FIN: begin
        if (!pass_q) begin
          tot_d   = pref;
          pass_d  = 1'b1;
          state_d = rast_pkg::ST_QRY_SET;
        end else begin
          tot_d   = tot_q - pref;
          state_d = rast_pkg::ST_OUT;
        end
      end
      rast_pkg::ST_OUT: begin
        // Hold until the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          load_val = tot_q;
          state_d  = rast_pkg::ST_IDLE;
        end
      end
      default: state_d = rast_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rast_pkg::ST_IDLE;
      len_q       <= LW'(NE);
      vld_q       <= '0;
      pass_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      if (cfg_acc) begin
        if (cfg_active_length_i == '0) begin
          len_q <= LW'(1);
        end else if (cfg_active_length_i > LW'(NE)) begin
          len_q <= LW'(NE);
        end else begin
          len_q <= cfg_active_length_i;
        end
      end
      if (clr) begin
        vld_q <= '0;
      end else if (ram_we) begin
        vld_q[ram_addr] <= 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    vld_rd_q <= vld_q[ram_addr];
    pos_q    <= pos_d;
    k_q      <= k_d;
    d1_q     <= d1_d;
    d2_q     <= d2_d;
    acc1_q   <= acc1_d;
    acc2_q   <= acc2_d;
    prod_q   <= prod_d;
    tot_q    <= tot_d;
    if (in_acc) begin
      cmd_q   <= cmd_i;
      left_q  <= left_index_i;
      rclip_q <= rclip;
      val_q   <= add_value_i;
    end
    if (load_out) begin
      out_data_q <= load_val;
    end
  end

  assign out_valid_o = out_valid_q;
  assign range_sum_o = out_data_q;

endmodule

// ===== design/rast_ram.sv =====
// ----------------------------------------------------------------------------
// rast_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module rast_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== design/rast_checker.sv =====
// ----------------------------------------------------------------------------
// rast_checker
// Port-level checks for the range add / range sum block.
// ----------------------------------------------------------------------------
module rast_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic [rast_pkg::CMD_W-1:0] cmd_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [rast_pkg::VAL_W-1:0] range_sum_o
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(range_sum_o))
    else $error("stalled result changed");

  // A sum keeps the block busy in the next cycle.
  a_sum_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (cmd_i == rast_pkg::CMD_SUM) |=> in_stall_o)
    else $error("sum did not occupy the block");

  // A clear leaves the input unstalled in the next cycle.
  a_clear_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (cmd_i == rast_pkg::CMD_CLEAR) |=> !in_stall_o)
    else $error("clear stalled the input");

  // No result during reset.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result valid in reset");

endmodule

bind range_add_range_sum_tree_core rast_checker u_rast_checker (.*);
